// ----- rtl/core/bpr_pkg.sv -----
// ----------------------------------------------------------------------------
// bpr_pkg: shared definitions for the byte pattern replacer
// Sizes, register indexes and the burst descriptor passed to the emitter.
// ----------------------------------------------------------------------------
package bpr_pkg;

    localparam int PATTERN_MAX = 8;
    localparam int REPLACE_MAX = 8;

    localparam int BYTE_W    = 8;
    localparam int REG_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 2;

    // registers hold eight bytes, so lengths saturate at eight as well
    localparam int NCELL   = (PATTERN_MAX < 8) ? PATTERN_MAX : 8;
    localparam int RLIM    = (REPLACE_MAX < 8) ? REPLACE_MAX : 8;
    localparam int WIN_W   = NCELL * BYTE_W;

    localparam logic [LEN_W-1:0] PLEN_LIM = LEN_W'(NCELL);
    localparam logic [LEN_W-1:0] RLEN_LIM = LEN_W'(RLIM);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEARCH_BYTES   = 2'd0,
        CFG_SEARCH_LENGTH  = 2'd1,
        CFG_REPLACE_BYTES  = 2'd2,
        CFG_REPLACE_LENGTH = 2'd3
    } t_cfg_idx;

    // one item's results: up to eight bytes, oldest in the low byte
    typedef struct packed {
        logic [REG_W-1:0] data;
        logic [LEN_W-1:0] count;
        logic             present;
        logic             str_end;
    } t_burst;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] lim);
        return (len > lim) ? lim : len;
    endfunction

endpackage

// ----- rtl/core/bpr_cell.sv -----
// ----------------------------------------------------------------------------
// bpr_cell: one window position
// Holds one unconfirmed byte, compares it with its pattern byte and takes
// its right-hand neighbour's byte when the window slides.
// ----------------------------------------------------------------------------
module bpr_cell (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_ins,
    input  logic                       i_shift,
    input  logic [bpr_pkg::BYTE_W-1:0] i_byte,
    input  logic [bpr_pkg::BYTE_W-1:0] i_next,
    input  logic [bpr_pkg::BYTE_W-1:0] i_pat,
    output logic [bpr_pkg::BYTE_W-1:0] o_tent,
    output logic                       o_eq
);

    logic [bpr_pkg::BYTE_W-1:0] r_byte;

    // byte as it stands once the incoming word is placed
    assign o_tent = i_ins ? i_byte : r_byte;
    assign o_eq   = (o_tent == i_pat);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_byte <= i_shift ? i_next : o_tent;
        end
    end

endmodule

// ----- rtl/core/bpr_emit.sv -----
// ----------------------------------------------------------------------------
// bpr_emit: result serialiser
// Holds one burst and hands it out a word per cycle while the output is not
// stalled; reloads on the cycle its final word leaves.
// ----------------------------------------------------------------------------
module bpr_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  bpr_pkg::t_burst            i_burst,
    output logic                       o_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [bpr_pkg::BYTE_W-1:0] o_out_byte,
    output logic                       o_byte_present,
    output logic                       o_run_last,
    output logic                       o_string_end
);

    logic [bpr_pkg::REG_W-1:0] r_data;
    logic [bpr_pkg::LEN_W-1:0] r_cnt;
    logic                      r_present;
    logic                      r_end;
    logic                      pop;
    logic                      final_word;

    assign final_word = (r_cnt == bpr_pkg::LEN_W'(1));
    assign pop        = (r_cnt != '0) && !i_out_stall;
    assign o_ready    = (r_cnt == '0) || (final_word && !i_out_stall);

    assign o_out_valid    = (r_cnt != '0);
    assign o_out_byte     = r_data[bpr_pkg::BYTE_W-1:0];
    assign o_byte_present = r_present;
    assign o_run_last     = final_word;
    assign o_string_end   = final_word && r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (pop) begin
            r_cnt <= r_cnt - bpr_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data    <= i_burst.data;
            r_present <= i_burst.present;
            r_end     <= i_burst.str_end;
        end else if (pop) begin
            r_data <= r_data >> bpr_pkg::BYTE_W;
        end
    end

endmodule

// ----- rtl/core/byte_pattern_replace.sv -----
// ----------------------------------------------------------------------------
// byte_pattern_replace: streaming find and replace over a byte string
// Left-to-right, non-overlapping pattern replacement with literal flush at
// end of string; a row of window cells feeds a burst serialiser.
// ----------------------------------------------------------------------------
// Output: first result word registered, valid in the cycle after its input word is accepted.
// Throughput: one input word per cycle while each word yields at most one
//   result and the output is not stalled; a word yielding more holds the input
//   off until its final result leaves the serialiser's single-word output port.
// Reset: synchronous, active low; clears config registers, window fill and
//   the serialiser count. Window bytes are not cleared.
// ----------------------------------------------------------------------------
module byte_pattern_replace (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [bpr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpr_pkg::REG_W-1:0]     i_cfg_data,
    // input words
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bpr_pkg::BYTE_W-1:0]    i_in_byte,
    input  logic                          i_in_last,
    // result words
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bpr_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                          o_byte_present,
    output logic                          o_run_last,
    output logic                          o_string_end
);

    localparam int NC = bpr_pkg::NCELL;
    localparam int LW = bpr_pkg::LEN_W;
    localparam int BW = bpr_pkg::BYTE_W;

    // config registers
    logic [bpr_pkg::REG_W-1:0] r_search_bytes;
    logic [bpr_pkg::REG_W-1:0] r_replace_bytes;
    logic [LW-1:0]             r_search_len;
    logic [LW-1:0]             r_replace_len;

    // window occupancy
    logic [LW-1:0] r_fill;
    logic [LW-1:0] n_fill;

    logic [LW-1:0] plen;
    logic [LW-1:0] rlen;
    logic [LW-1:0] fill_eff;
    logic [LW-1:0] fill_inc;
    logic          bypass;
    logic          full;
    logic          match;
    logic          shift;
    logic          accept;
    logic          emit_ready;
    logic          cell_en;

    logic [NC-1:0]       cell_eq;
    logic [NC-1:0]       cell_used;
    logic [BW-1:0]       tent [NC];
    logic [NC*BW-1:0]    window;

    bpr_pkg::t_burst burst;

    assign plen     = bpr_pkg::sat_len(r_search_len, bpr_pkg::PLEN_LIM);
    assign rlen     = bpr_pkg::sat_len(r_replace_len, bpr_pkg::RLEN_LIM);
    assign bypass   = (plen == '0);
    // a stale fill at or past the length restarts the window
    assign fill_eff = (r_fill >= plen) ? '0 : r_fill;
    assign fill_inc = fill_eff + LW'(1);
    assign full     = !bypass && (fill_inc == plen);
    assign match    = full && (&(cell_eq | ~cell_used));
    // slide on a full mismatch; on end of string the window is dropped anyway
    assign shift    = full && !match && !i_in_last;

    assign o_in_stall = !emit_ready;
    assign accept     = i_in_valid && emit_ready;
    assign cell_en    = accept && !bypass;

    // ---- row of window cells ------------------------------------------------
    for (genvar k = 0; k < NC; k++) begin : g_cell
        logic [BW-1:0] next_byte;

        if (k == NC - 1) begin : g_end
            assign next_byte = '0;
        end else begin : g_mid
            assign next_byte = tent[k+1];
        end

        assign cell_used[k]           = (LW'(k) < plen);
        assign window[k*BW +: BW]     = tent[k];

        bpr_cell u_cell (
            .i_clk   (i_clk),
            .i_en    (cell_en),
            .i_ins   (fill_eff == LW'(k)),
            .i_shift (shift),
            .i_byte  (i_in_byte),
            .i_next  (next_byte),
            .i_pat   (r_search_bytes[k*BW +: BW]),
            .o_tent  (tent[k]),
            .o_eq    (cell_eq[k])
        );
    end

    // ---- results of the current word -----------------------------------------
    always_comb begin
        burst.present = 1'b1;
        burst.str_end = i_in_last;
        if (bypass) begin
            burst.data  = bpr_pkg::REG_W'(i_in_byte);
            burst.count = LW'(1);
        end else if (match) begin
            burst.data  = r_replace_bytes;
            burst.count = rlen;
        end else if (full) begin
            // oldest byte out; on end of string the rest follows in order
            burst.data  = bpr_pkg::REG_W'(window);
            burst.count = i_in_last ? plen : LW'(1);
        end else begin
            burst.data  = bpr_pkg::REG_W'(window);
            burst.count = i_in_last ? fill_inc : '0;
        end
        // end of string with nothing to say: bare end marker
        if (i_in_last && (burst.count == '0)) begin
            burst.data    = '0;
            burst.count   = LW'(1);
            burst.present = 1'b0;
        end
    end

    always_comb begin
        if (bypass || i_in_last || match) begin
            n_fill = '0;
        end else if (full) begin
            n_fill = plen - LW'(1);
        end else begin
            n_fill = fill_inc;
        end
    end

    bpr_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept && (burst.count != '0)),
        .i_burst        (burst),
        .o_ready        (emit_ready),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_run_last     (o_run_last),
        .o_string_end   (o_string_end)
    );

    // ---- config and fill registers -------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_search_bytes  <= '0;
            r_search_len    <= '0;
            r_replace_bytes <= '0;
            r_replace_len   <= '0;
        end else if (i_cfg_we) begin
            case (bpr_pkg::t_cfg_idx'(i_cfg_index))
                bpr_pkg::CFG_SEARCH_BYTES:   r_search_bytes  <= i_cfg_data;
                bpr_pkg::CFG_SEARCH_LENGTH:  r_search_len    <= i_cfg_data[LW-1:0];
                bpr_pkg::CFG_REPLACE_BYTES:  r_replace_bytes <= i_cfg_data;
                bpr_pkg::CFG_REPLACE_LENGTH: r_replace_len   <= i_cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cfg_we &&
                     (bpr_pkg::t_cfg_idx'(i_cfg_index) == bpr_pkg::CFG_SEARCH_LENGTH)) begin
            // new length drops any unconfirmed bytes
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

endmodule

// ----- tb/sv/byte_pattern_replace_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_pattern_replace_tb: self-checking bench for the streaming replacer
// Drives byte strings through the valid/stall input channel and checks each
// result word against an in-bench prediction of the find-and-replace window.
// A directed opening covers pass-through, matches, flushes, bare end markers,
// empty replacements, length changes mid-string and oversized lengths; random
// phases follow, each with its own register setting and idling pattern.
// ----------------------------------------------------------------------------
module byte_pattern_replace_tb;

    localparam int unsigned CYCLE_LIMIT  = 300000;
    // quiet cycles after the last expected word; covers the registered output
    // stage and any word still inside the block that yields no result
    localparam int unsigned QUIET_CYCLES = 16;

    // one input word and one result word as the ports carry them
    typedef struct packed {
        logic [bpr_pkg::BYTE_W-1:0] data;
        logic                       last;
    } t_src_word;

    typedef struct packed {
        logic [bpr_pkg::BYTE_W-1:0] data;
        logic                       present;
        logic                       run_last;
        logic                       str_end;
    } t_res_word;

    // idling patterns, one per phase
    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_cfg_we       = 1'b0;
    logic [bpr_pkg::CFG_IDX_W-1:0] i_cfg_index    = bpr_pkg::CFG_SEARCH_BYTES;
    logic [bpr_pkg::REG_W-1:0]     i_cfg_data     = '0;
    logic                          i_in_valid     = 1'b0;
    logic                          o_in_stall;
    logic [bpr_pkg::BYTE_W-1:0]    i_in_byte      = '0;
    logic                          i_in_last      = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall    = 1'b0;
    logic [bpr_pkg::BYTE_W-1:0]    o_out_byte;
    logic                          o_byte_present;
    logic                          o_run_last;
    logic                          o_string_end;

    t_src_word   source_q [$];   // words waiting to be driven
    t_res_word   result_q [$];   // predicted result words, oldest first
    t_idle_mode  idle_mode  = IDLE_NONE;
    logic        in_taken   = 1'b0;   // input word accepted at the last rising edge
    int unsigned cycle_count = 0;
    int unsigned fail_count  = 0;

    // shadow of the registers and of the match window
    logic [bpr_pkg::REG_W-1:0]  pat_bytes   = '0;
    logic [bpr_pkg::LEN_W-1:0]  pat_len_reg = '0;
    logic [bpr_pkg::REG_W-1:0]  rep_bytes   = '0;
    logic [bpr_pkg::LEN_W-1:0]  rep_len_reg = '0;
    logic [bpr_pkg::BYTE_W-1:0] win [bpr_pkg::NCELL];
    int unsigned                win_fill    = 0;

    byte_pattern_replace dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .i_in_last      (i_in_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_run_last     (o_run_last),
        .o_string_end   (o_string_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction: one accepted word in, its result words appended to result_q.
    // Lengths saturate at the window size; a full window either matches (emit
    // the replacement, clear) or gives up its oldest byte. End of string
    // flushes what is left, or a bare end marker when nothing was produced.
    // ------------------------------------------------------------------------
    task automatic predict_replace(input logic [bpr_pkg::BYTE_W-1:0] d, input logic last);
        int unsigned plen;
        int unsigned rlen;
        int unsigned k;
        bit          hit;
        t_res_word   words [$];
        t_res_word   w;
        plen = (pat_len_reg > bpr_pkg::NCELL) ? bpr_pkg::NCELL : pat_len_reg;
        rlen = (rep_len_reg > bpr_pkg::RLIM) ? bpr_pkg::RLIM : rep_len_reg;
        if (plen == 0) begin
            win_fill = 0;
            words.push_back('{d, 1'b1, 1'b0, 1'b0});
        end else begin
            if (win_fill >= plen) begin
                win_fill = 0;
            end
            win[win_fill] = d;
            win_fill++;
            if (win_fill == plen) begin
                hit = 1'b1;
                for (k = 0; k < plen; k++) begin
                    if (win[k] != pat_bytes[8*k +: 8]) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    for (k = 0; k < rlen; k++) begin
                        words.push_back('{rep_bytes[8*k +: 8], 1'b1, 1'b0, 1'b0});
                    end
                    win_fill = 0;
                end else begin
                    words.push_back('{win[0], 1'b1, 1'b0, 1'b0});
                    for (k = 1; k < win_fill; k++) begin
                        win[k-1] = win[k];
                    end
                    win_fill--;
                end
            end
        end
        if (last) begin
            for (k = 0; k < win_fill; k++) begin
                words.push_back('{win[k], 1'b1, 1'b0, 1'b0});
            end
            win_fill = 0;
            if (words.size() == 0) begin
                words.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
            end
        end
        // markers on the final word of this input
        for (k = 0; k < words.size(); k++) begin
            w = words[k];
            if (k == words.size() - 1) begin
                w.run_last = 1'b1;
                w.str_end  = last;
            end
            result_q.push_back(w);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: inputs move on the falling edge. A new word (or an idle slot) is
    // chosen only once the current one has gone; a stalled word holds still.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_source
        t_src_word nxt;
        bit        idle_now;
        if (!i_in_valid || in_taken) begin
            idle_now = (idle_mode == IDLE_SENDER && $urandom_range(99) < 56) ||
                       (idle_mode == IDLE_BOTH   && $urandom_range(99) < 19);
            if (source_q.size() != 0 && !idle_now) begin
                nxt        = source_q.pop_front();
                i_in_valid <= 1'b1;
                i_in_byte  <= nxt.data;
                i_in_last  <= nxt.last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= (idle_mode == IDLE_RECEIVER && $urandom_range(99) < 56) ||
                       (idle_mode == IDLE_BOTH     && $urandom_range(99) < 19);
    end

    // ------------------------------------------------------------------------
    // Monitor: samples at the rising edge. Prediction runs before the check,
    // so a word accepted on this edge is already queued.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        t_res_word want;
        cycle_count <= cycle_count + 1;
        in_taken    <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            predict_replace(i_in_byte, i_in_last);
        end
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (result_q.size() == 0) begin
                $error("unexpected result word: out_byte %02h", o_out_byte);
                fail_count++;
            end else begin
                want = result_q.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte: expected %02h, got %02h", want.data, o_out_byte);
                    fail_count++;
                end
                if (o_byte_present !== want.present) begin
                    $error("byte_present: expected %0b, got %0b",
                           want.present, o_byte_present);
                    fail_count++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last: expected %0b, got %0b", want.run_last, o_run_last);
                    fail_count++;
                end
                if (o_string_end !== want.str_end) begin
                    $error("string_end: expected %0b, got %0b",
                           want.str_end, o_string_end);
                    fail_count++;
                end
            end
        end
    end

    // hung handshake guard
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("byte_pattern_replace regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic put_word(input logic [bpr_pkg::BYTE_W-1:0] d, input logic last);
        source_q.push_back('{d, last});
    endtask

    // ASCII text, end of string on the final character if asked
    task automatic put_text(input string s, input bit ends);
        int k;
        for (k = 0; k < s.len(); k++) begin
            put_word(s[k], ends && (k == s.len() - 1));
        end
    endtask

    // block is idle: nothing queued, nothing in flight, nothing outstanding
    task automatic drain();
        while (source_q.size() != 0 || i_in_valid || result_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // register write; only called with the block idle, so the shadow may
    // change at once
    task automatic write_reg(input bpr_pkg::t_cfg_idx idx,
                             input logic [bpr_pkg::REG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            bpr_pkg::CFG_SEARCH_BYTES: begin
                pat_bytes = value;
            end
            bpr_pkg::CFG_SEARCH_LENGTH: begin
                pat_len_reg = value[bpr_pkg::LEN_W-1:0];
                win_fill    = 0;   // unconfirmed bytes are dropped
            end
            bpr_pkg::CFG_REPLACE_BYTES: begin
                rep_bytes = value;
            end
            default: begin
                rep_len_reg = value[bpr_pkg::LEN_W-1:0];
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_all(input logic [bpr_pkg::REG_W-1:0] pat,
                           input logic [bpr_pkg::LEN_W-1:0] plen,
                           input logic [bpr_pkg::REG_W-1:0] rep,
                           input logic [bpr_pkg::LEN_W-1:0] rlen);
        write_reg(bpr_pkg::CFG_SEARCH_BYTES,   pat);
        write_reg(bpr_pkg::CFG_SEARCH_LENGTH,  bpr_pkg::REG_W'(plen));
        write_reg(bpr_pkg::CFG_REPLACE_BYTES,  rep);
        write_reg(bpr_pkg::CFG_REPLACE_LENGTH, bpr_pkg::REG_W'(rlen));
    endtask

    // ------------------------------------------------------------------------
    // Random phase: a fresh setting, then strings that are mostly built from
    // pattern copies, pattern prefixes and the pattern's own bytes (so matches
    // and near misses are common), the rest plain noise. A phase sometimes
    // stops mid-string, so the next length write drops a partial window.
    // ------------------------------------------------------------------------
    task automatic run_random_phase(input int unsigned n_words);
        logic [bpr_pkg::BYTE_W-1:0] alpha [3];
        logic [bpr_pkg::REG_W-1:0]  pat;
        logic [bpr_pkg::LEN_W-1:0]  plen_raw;
        int unsigned                plen;
        int unsigned                sent;
        int unsigned                r;
        int unsigned                seg_len;
        int unsigned                cut;
        int unsigned                k;
        logic [bpr_pkg::BYTE_W-1:0] str [$];
        bit                         open_end;
        for (k = 0; k < 3; k++) begin
            alpha[k] = bpr_pkg::BYTE_W'($urandom);
        end
        r = $urandom_range(99);
        if (r < 5) begin
            plen_raw = '0;
        end else if (r < 15) begin
            plen_raw = bpr_pkg::LEN_W'($urandom_range(15, 9));
        end else if (r < 35) begin
            plen_raw = bpr_pkg::LEN_W'($urandom_range(8, 5));
        end else begin
            plen_raw = bpr_pkg::LEN_W'($urandom_range(4, 1));
        end
        if ($urandom_range(9) == 0) begin
            pat = {$urandom, $urandom};
        end else begin
            for (k = 0; k < 8; k++) begin
                pat[8*k +: 8] = alpha[$urandom_range(2)];
            end
        end
        set_all(pat, plen_raw, {$urandom, $urandom},
                bpr_pkg::LEN_W'($urandom_range(15)));

        // content shape only; pass-through still gets pattern-like strings
        plen = (plen_raw > bpr_pkg::NCELL) ? bpr_pkg::NCELL : plen_raw;
        if (plen == 0) begin
            plen = 3;
        end
        sent = 0;
        while (sent < n_words) begin
            str.delete();
            if ($urandom_range(99) < 70) begin
                seg_len = $urandom_range(24, 1);
                while (str.size() < seg_len) begin
                    r = $urandom_range(99);
                    if (r < 40) begin
                        for (k = 0; k < plen; k++) begin
                            str.push_back(pat[8*k +: 8]);
                        end
                    end else if (r < 65) begin
                        cut = $urandom_range(plen - 1);
                        for (k = 0; k < cut; k++) begin
                            str.push_back(pat[8*k +: 8]);
                        end
                    end else begin
                        str.push_back(alpha[$urandom_range(2)]);
                    end
                end
            end else begin
                seg_len = $urandom_range(12, 1);
                for (k = 0; k < seg_len; k++) begin
                    str.push_back(bpr_pkg::BYTE_W'($urandom));
                end
            end
            open_end = (sent + str.size() >= n_words) && ($urandom_range(3) == 0);
            for (k = 0; k < str.size(); k++) begin
                put_word(str[k], (k == str.size() - 1) && !open_end);
            end
            sent += str.size();
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin : run_sequence
        int p;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // pass-through with all registers at zero, byte extremes
        set_all('0, '0, '0, '0);
        put_word(8'h00, 1'b0);
        put_word(8'hFF, 1'b1);
        drain();

        // "abc" -> "XY": a miss, two matches, the second closing the string
        set_all(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_0000_5958, 4'd2);
        put_text("xabcabc", 1'b1);
        drain();

        // empty replacement: a match on the final word leaves a bare end
        // marker; a match mid-string yields nothing, then the tail is flushed
        write_reg(bpr_pkg::CFG_REPLACE_LENGTH, bpr_pkg::REG_W'(0));
        put_text("abc", 1'b1);
        put_text("abcab", 1'b1);
        drain();

        // length rewritten mid-string drops the two held bytes
        put_text("ab", 1'b0);
        drain();
        write_reg(bpr_pkg::CFG_SEARCH_LENGTH, bpr_pkg::REG_W'(3));
        put_text("c", 1'b1);
        drain();

        // oversized lengths saturate: eight 0xFF bytes become eight new ones
        set_all('1, 4'd15, 64'h0011_2233_4455_6677, 4'd15);
        for (p = 0; p < 8; p++) begin
            put_word(8'hFF, p == 7);
        end
        drain();

        // random phases, idling pattern rotating through all four
        for (p = 0; p < 8; p++) begin
            idle_mode = t_idle_mode'(p % 4);
            run_random_phase(45);
        end

        drain();
        if (fail_count == 0 && result_q.size() == 0) begin
            $display("byte_pattern_replace regression: pass");
        end else begin
            $display("byte_pattern_replace regression: fail");
        end
        $finish;
    end

endmodule
